/* rtl/frac_pkg.sv */
// Package for the fraction reduction block: controller states and the command
// and status bundles that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frac_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUC_CHECK,
		ST_EUC_WAIT,
		ST_DIVN_WAIT,
		ST_DIVD_WAIT,
		ST_FINISH
	} frac_state_t;

	// Which operands the shared divider works on.
	typedef enum logic [1:0] {
		DIV_EUCLID,
		DIV_NUM,
		DIV_DEN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     euclid_step;
		logic     capture_qn;
		logic     capture_qd;
		logic     out_write;
	} frac_cmd_t;

	typedef struct packed {
		logic b_zero;
		logic div_done;
		logic out_busy;
	} frac_sts_t;

endpackage

`default_nettype wire

/* rtl/fraction_reduce_top.sv */
// A request takes E >= 1 Euclid remainder steps and then two final divisions; each step
// and both final divisions use one shared restoring divider that produces one quotient
// bit per cycle.
// One request is worked on at a time; a result may wait in the output register while
// the next request is worked on.
// Reset: arst_n clears the controller and the output valid flag asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module fraction_reduce_top #(
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// Request side.
	input  wire logic s_tvalid,
	output logic      s_tready,
	// tdata, lowest bit up: numerator_in, denominator_in, zero padding.
	input  wire logic [((2*WORD_BITS+7)/8)*8-1:0] s_tdata,
	// Result side.
	output logic      m_tvalid,
	input  wire logic m_tready,
	// tdata, lowest bit up: numerator_out, denominator_out, zero padding.
	output logic [((2*WORD_BITS-1+7)/8)*8-1:0] m_tdata
);

	localparam int W     = WORD_BITS;
	localparam int OUT_W = ((2*WORD_BITS-1+7)/8)*8;

	frac_pkg::frac_cmd_t cmd;
	frac_pkg::frac_sts_t sts;
	logic [W-1:0]        num_out;
	logic [W-2:0]        den_out;

	// The controller decides the order of Euclid steps and final divisions;
	// the datapath holds all operands and the output register.
	frac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frac_dp #(.W(W)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.num_in    (s_tdata[W-1:0]),
		.den_in    (s_tdata[2*W-1:W]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.num_out   (num_out),
		.den_out   (den_out)
	);

	// Padding bits above the denominator are zero.
	assign m_tdata = OUT_W'({den_out, num_out});

	// The reduced denominator is never zero.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*W-2:W] != '0))
		else $error("reduced denominator is zero");

	// A zero numerator always comes out as 0/1.
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[W-1:0] == '0)) |-> (m_tdata[2*W-2:W] == (W-1)'(1)))
		else $error("zero numerator without unit denominator");

	// A new result is only loaded while the block is busy with a request.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a request in progress");

endmodule

`default_nettype wire

/* rtl/frac_div.sv */
// Restoring unsigned divider for the fraction reduction block: one quotient
// bit per cycle. Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frac_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   rem_sh;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_next;

	assign rem_sh   = {rem_q, quo_q[W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/frac_dp.sv */
// Datapath of the fraction reduction block: magnitudes, Euclid registers,
// quotients and the output register. Uses frac_pkg and frac_div.
`timescale 1ns / 1ps
`default_nettype none

module frac_dp #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire frac_pkg::frac_cmd_t cmd,
	output frac_pkg::frac_sts_t      sts,
	input  wire logic [W-1:0]        num_in,
	input  wire logic [W-1:0]        den_in,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [W-1:0]             num_out,
	output logic [W-2:0]             den_out
);

	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

	logic [W-1:0] mn_q, md_q, a_q, b_q, qn_q, qd_q;
	logic         nneg_q, dneg_q;
	logic [W-1:0] num_q;
	logic [W-2:0] den_q;
	logic         valid_q;

	logic [W-1:0] mag_n, mag_d;
	logic [W-1:0] div_a, div_b;
	logic         div_done;
	logic [W-1:0] div_quo, div_rem;
	logic         neg;
	logic [W-1:0] num_next;
	logic [W-2:0] den_next;

	// Two's complement magnitude; the most negative value maps to 2^(W-1).
	assign mag_n = num_in[W-1] ? (~num_in + 1'b1) : num_in;
	assign mag_d = den_in[W-1] ? (~den_in + 1'b1) : den_in;

	// Euclid steps divide a by b; the final divisions divide by the gcd held in a.
	always_comb begin
		case (cmd.div_sel)
			frac_pkg::DIV_EUCLID: begin
				div_a = a_q;
				div_b = b_q;
			end
			frac_pkg::DIV_NUM: begin
				div_a = mn_q;
				div_b = a_q;
			end
			frac_pkg::DIV_DEN: begin
				div_a = md_q;
				div_b = a_q;
			end
			default: begin
				div_a = a_q;
				div_b = b_q;
			end
		endcase
	end

	frac_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mn_q   <= mag_n;
			nneg_q <= num_in[W-1];
			if (mag_d == '0) begin
				md_q   <= W'(1);
				b_q    <= W'(1);
				dneg_q <= 1'b0;
			end else begin
				md_q   <= mag_d;
				b_q    <= mag_d;
				dneg_q <= den_in[W-1];
			end
			a_q <= mag_n;
		end else if (cmd.euclid_step) begin
			a_q <= b_q;
			b_q <= div_rem;
		end
		if (cmd.capture_qn) begin
			qn_q <= div_quo;
		end
		if (cmd.capture_qd) begin
			qd_q <= div_quo;
		end
	end

	// Sign goes on the numerator; a zero numerator gets denominator 1; positive values saturate at the largest value.
	always_comb begin
		neg = (nneg_q != dneg_q) && (qn_q != '0);
		if (neg) begin
			num_next = ~qn_q + 1'b1;
		end else if (qn_q[W-1]) begin
			num_next = MAXPOS;
		end else begin
			num_next = qn_q;
		end
		if (qn_q == '0) begin
			den_next = (W-1)'(1);
		end else if (qd_q[W-1]) begin
			den_next = MAXPOS[W-2:0];
		end else begin
			den_next = qd_q[W-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			num_q <= num_next;
			den_q <= den_next;
		end
	end

	assign out_valid    = valid_q;
	assign num_out      = num_q;
	assign den_out      = den_q;
	assign sts.b_zero   = (b_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_busy = valid_q && !out_ready;

endmodule

`default_nettype wire

/* rtl/frac_ctrl.sv */
// Controller of the fraction reduction block: sequences Euclid steps and the
// two final divisions on the shared divider. Uses frac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frac_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire frac_pkg::frac_sts_t sts,
	output frac_pkg::frac_cmd_t      cmd
);

	frac_pkg::frac_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = frac_pkg::DIV_EUCLID;
		in_ready    = 1'b0;
		case (state_q)
			frac_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = frac_pkg::ST_EUC_CHECK;
				end
			end
			frac_pkg::ST_EUC_CHECK: begin
				cmd.div_start = 1'b1;
				if (sts.b_zero) begin
					cmd.div_sel = frac_pkg::DIV_NUM;
					state_d     = frac_pkg::ST_DIVN_WAIT;
				end else begin
					state_d = frac_pkg::ST_EUC_WAIT;
				end
			end
			frac_pkg::ST_EUC_WAIT: begin
				if (sts.div_done) begin
					cmd.euclid_step = 1'b1;
					state_d         = frac_pkg::ST_EUC_CHECK;
				end
			end
			frac_pkg::ST_DIVN_WAIT: begin
				cmd.div_sel = frac_pkg::DIV_NUM;
				if (sts.div_done) begin
					cmd.capture_qn = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_sel    = frac_pkg::DIV_DEN;
					state_d        = frac_pkg::ST_DIVD_WAIT;
				end
			end
			frac_pkg::ST_DIVD_WAIT: begin
				cmd.div_sel = frac_pkg::DIV_DEN;
				if (sts.div_done) begin
					cmd.capture_qd = 1'b1;
					state_d        = frac_pkg::ST_FINISH;
				end
			end
			frac_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_write = 1'b1;
					state_d       = frac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frac_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for fraction_reduce_top: streams signed fractions in,
// predicts each lowest-terms result and checks it field by field on the way out.
// Depends only on the RTL of fraction_reduce_top.
`timescale 1ns / 1ps

module tb_top;

	localparam int W = 32;
	localparam int S_W = ((2 * W + 7) / 8) * 8;
	localparam int M_W = ((2 * W - 1 + 7) / 8) * 8;
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W - 1){1'b1}}};
	localparam int MAX_MAG = 32'h7FFF_FFFF;

	// Bound on the run time of one request; the Euclid step count is at most about 46 for 32 bits.
	localparam int MAX_ITEM_CYCLES = 3 + 48 * (W + 2) + 2 * (W + 1);
	localparam int N_ITEMS = 1750;
	localparam int GAP_MAX = 600;
	localparam int STALL_MAX = 1500;
	localparam int LONG_HOLD = 3 * MAX_ITEM_CYCLES;
	localparam int LONG_HOLD_AT = 400;
	localparam int RUN_LIMIT =
		2 * ((N_ITEMS + 25) * (MAX_ITEM_CYCLES + GAP_MAX + STALL_MAX) + LONG_HOLD + 100);

	typedef struct {
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		bit                  drain_first;  // wait for every result before offering this one
	} frac_req_t;

	typedef struct {
		logic signed [W-1:0] num;
		logic [W-2:0]        den;
	} frac_res_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;

	frac_req_t pending_fracs[$];
	frac_res_t expected_reduced[$];
	logic req_fire = 1'b0;
	int fail_count = 0;
	int results_seen = 0;

	fraction_reduce_top #(.WORD_BITS(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	// Lowest terms by Euclid on the magnitudes; the sign rides on the numerator.
	function automatic frac_res_t reduce_fraction(input frac_req_t req);
		logic [W-1:0] mag_n, mag_d, a, b, rem, qn, qd;
		logic neg_n, neg_d;
		frac_res_t res;
		neg_n = req.num[W-1];
		neg_d = req.den[W-1];
		mag_n = neg_n ? -req.num : req.num;
		mag_d = neg_d ? -req.den : req.den;
		if (mag_d == '0) begin
			mag_d = 1;
			neg_d = 1'b0;
		end
		a = mag_n;
		b = mag_d;
		while (b != '0) begin
			rem = a % b;
			a = b;
			b = rem;
		end
		qn = mag_n / a;
		qd = mag_d / a;
		if (qn == '0)
			qd = 1;
		if (neg_n != neg_d && qn != '0)
			res.num = -qn;
		else
			res.num = (qn > MAX_POS) ? MAX_POS : qn;
		res.den = (qd > MAX_POS) ? MAX_POS[W-2:0] : qd[W-2:0];
		return res;
	endfunction

	function automatic logic [S_W-1:0] pack_request(input frac_req_t req);
		logic [S_W-1:0] v;
		v = '0;
		v[W-1:0] = req.num;
		v[2*W-1:W] = req.den;
		return v;
	endfunction

	function automatic int rand_magnitude(input int bits);
		int unsigned m;
		m = $urandom;
		if (bits < 32)
			m = m & ((32'd1 << bits) - 1);
		return int'(m);
	endfunction

	function automatic int with_sign(input int m);
		return ($urandom_range(0, 1) == 1) ? -m : m;
	endfunction

	// Any 32-bit pattern except the most negative value.
	function automatic int full_range();
		int v;
		v = $urandom;
		if (v == 32'h8000_0000)
			v = 32'h8000_0001;
		return v;
	endfunction

	task automatic add_request(input int n, input int d, input bit drain);
		frac_req_t req;
		req.num = n;
		req.den = d;
		req.drain_first = drain;
		pending_fracs.push_back(req);
	endtask

	initial begin : stimulus
		int kind, wg, wa, wb, gfac, n, d;

		// Directed part: zeros, sign combinations, extremes and a worst-case Euclid chain.
		add_request(0, 5, 1'b0);
		add_request(0, -7, 1'b0);
		add_request(0, 0, 1'b0);
		add_request(5, 0, 1'b0);
		add_request(-5, 0, 1'b0);
		add_request(1, 1, 1'b0);
		add_request(MAX_MAG, 1, 1'b0);
		add_request(-MAX_MAG, 1, 1'b0);
		add_request(MAX_MAG, -1, 1'b0);
		add_request(-MAX_MAG, -MAX_MAG, 1'b0);
		add_request(MAX_MAG, MAX_MAG, 1'b0);
		add_request(1, MAX_MAG, 1'b0);
		add_request(-1, -MAX_MAG, 1'b0);
		add_request(6, 4, 1'b0);
		add_request(-6, 4, 1'b0);
		add_request(6, -4, 1'b0);
		add_request(-6, -4, 1'b0);
		add_request(1836311903, 1134903170, 1'b0);
		add_request(-1134903170, 1836311903, 1'b0);
		add_request(MAX_MAG, MAX_MAG - 1, 1'b0);
		add_request(1073741824, -1073741824, 1'b0);
		add_request(223092870, -9699690, 1'b0);

		// Random part. The first request and one in the middle wait for the pipe to drain.
		for (int i = 0; i < N_ITEMS - 22; i++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				// Shared factor, so the reduction has real work to do.
				wg = $urandom_range(1, 30);
				wa = $urandom_range(1, 31 - wg);
				wb = $urandom_range(1, 31 - wg);
				gfac = rand_magnitude(wg);
				if (gfac == 0)
					gfac = 1;
				n = with_sign(rand_magnitude(wa) * gfac);
				d = with_sign(rand_magnitude(wb) * gfac);
			end else if (kind <= 5) begin
				n = full_range();
				d = full_range();
			end else if (kind <= 7) begin
				n = with_sign($urandom_range(0, 1000));
				d = with_sign($urandom_range(0, 1000));
			end else if (kind == 8) begin
				if ($urandom_range(0, 1) == 1) begin
					n = 0;
					d = full_range();
				end else begin
					n = full_range();
					d = 0;
				end
			end else begin
				n = with_sign(MAX_MAG);
				d = ($urandom_range(0, 1) == 1) ? full_range() : with_sign($urandom_range(1, 64));
				if ($urandom_range(0, 1) == 1) begin
					gfac = n;
					n = d;
					d = gfac;
				end
			end
			add_request(n, d, i == 0 || i == (N_ITEMS - 22) / 2);
		end

		@(posedge arst_n);
		while (pending_fracs.size() != 0 || expected_reduced.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_ITEM_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Request driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (req_fire)
				void'(pending_fracs.pop_front());
			// An offered request stays on the bus until it is taken.
			if (!s_tvalid || req_fire) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_fracs.size() == 0 ||
				             (pending_fracs[0].drain_first && expected_reduced.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= pack_request(pending_fracs[0]);
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, GAP_MAX)
						                                       : $urandom_range(0, 10);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Result receiver: alternating ready and stall runs, plus one long hold-off that
	// backs the block up until it refuses requests.
	int hold_left = 0;
	int run_left = 0;
	bit ready_phase = 1'b0;
	bit long_hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else begin
			if (run_left == 0) begin
				ready_phase = !ready_phase;
				if (ready_phase) begin
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 1500)
					                                       : $urandom_range(1, 40);
				end else begin
					kind_sel: case ($urandom_range(0, 19))
						0: begin
							run_left = $urandom_range(800, STALL_MAX);
						end
						1, 2, 3, 4, 5: begin
							run_left = $urandom_range(20, 200);
						end
						default: begin
							run_left = $urandom_range(1, 6);
						end
					endcase
				end
			end
			run_left--;
			m_tready <= ready_phase;
		end
	end

	// Checker: results are compared in order; each taken request queues its expectation.
	always @(posedge clk) begin : check_results
		frac_res_t got, want;
		frac_req_t req;
		req_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got.num = m_tdata[W-1:0];
			got.den = m_tdata[2*W-2:W];
			results_seen++;
			if (expected_reduced.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result %0d/%0d, no request outstanding",
				         $time, got.num, got.den);
			end else begin
				want = expected_reduced.pop_front();
				if (got.num !== want.num) begin
					fail_count++;
					$display("%0t: numerator mismatch, expected %0d, got %0d",
					         $time, want.num, got.num);
				end
				if (got.den !== want.den) begin
					fail_count++;
					$display("%0t: denominator mismatch, expected %0d, got %0d",
					         $time, want.den, got.den);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			req.num = s_tdata[W-1:0];
			req.den = s_tdata[2*W-1:W];
			req.drain_first = 1'b0;
			expected_reduced.push_back(reduce_fraction(req));
		end
	end

endmodule
